// ===== rtl/integrity_tree_metadata_address_gen_defines.svh =====
// ----------------------------------------------------------------------------
// Integrity tree metadata address generator - assertion macros
// Shared property forms, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGRITY_TREE_METADATA_ADDRESS_GEN_DEFINES_SVH
`define INTEGRITY_TREE_METADATA_ADDRESS_GEN_DEFINES_SVH

// same-cycle implication
`define ITMAG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("itmag: same-cycle check failed");

// next-cycle implication
`define ITMAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("itmag: next-cycle check failed");

`endif

// ===== rtl/itmag_pkg.sv =====
// ----------------------------------------------------------------------------
// itmag_pkg
// Types, constants and codes shared by the metadata address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package itmag_pkg;

    localparam int ADDR_BITS        = 40;
    localparam int EXTRA_LEVELS     = 7;
    localparam int RESPONSES_NEEDED = 10;
    localparam int NUM_WRITES       = 3 + EXTRA_LEVELS;
    localparam int STEP_W           = $clog2(NUM_WRITES);
    localparam int CNT_W            = 4;
    localparam int FIELD_W          = 40;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDR_BITS-1:0] aw_t;

    localparam aw_t FIRST_UPPER_SIZE = aw_t'(64'h0000_0000_0200_0000);
    localparam logic [6:0] MAC_BYTES   = 7'd8;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [FIELD_W-1:0] DATA_LIMIT_RST = 40'h04_0000_0000;

    localparam logic KIND_WRITE    = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    localparam logic [1:0] RK_META     = 2'd0;
    localparam logic [1:0] RK_BUSY     = 2'd1;
    localparam logic [1:0] RK_RANGE    = 2'd2;
    localparam logic [1:0] RK_COMPLETE = 2'd3;

    localparam logic [1:0] REG_MAC_BASE     = 2'd0;
    localparam logic [1:0] REG_COUNTER_BASE = 2'd1;
    localparam logic [1:0] REG_TREE_BASE    = 2'd2;
    localparam logic [1:0] REG_DATA_LIMIT   = 2'd3;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] addr;
    } in_req_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [FIELD_W-1:0] out_addr;
        logic [6:0]         size_bytes;
        logic               last;
    } out_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] mac_base;
        logic [FIELD_W-1:0] counter_base;
        logic [FIELD_W-1:0] tree_base;
        logic [FIELD_W-1:0] data_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_RUN,
        CMD_REJECT,
        CMD_ERROR,
        CMD_COMPLETE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [FIELD_W-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] resp_cnt;
    } fe_status_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/itmag_front.sv =====
// ----------------------------------------------------------------------------
// itmag_front
// Accepts requests, tracks the outstanding run and classifies each write
// request, and the response that ends a run, into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module itmag_front
    import itmag_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       s_valid,
    output      logic       s_ready,
    input  wire in_req_t    s_data,
    input  wire q_status_t  q_status,
    output      q_push_t    push,
    output      fe_status_t status
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [FIELD_W-1:0] pending_reg, pending_next;
    logic [CNT_W-1:0] cnt_inc;
    logic             accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign cnt_inc = cnt_reg + CNT_W'(1);

    always_comb begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        pending_next  = pending_reg;
        push.valid    = 1'b0;
        push.cmd.op   = CMD_RUN;
        push.cmd.addr = s_data.addr;
        if (accept) begin
            if (s_data.kind == KIND_RESPONSE) begin
                if (busy_reg) begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= CNT_W'(RESPONSES_NEEDED)) begin
                        push.valid    = 1'b1;
                        push.cmd.op   = CMD_COMPLETE;
                        push.cmd.addr = pending_reg;
                        busy_next     = 1'b0;
                        cnt_next      = '0;
                    end
                end
            end else if (busy_reg) begin
                push.valid  = 1'b1;
                push.cmd.op = CMD_REJECT;
            end else if (s_data.addr >= cfg.data_limit) begin
                push.valid  = 1'b1;
                push.cmd.op = CMD_ERROR;
            end else begin
                push.valid   = 1'b1;
                push.cmd.op  = CMD_RUN;
                busy_next    = 1'b1;
                cnt_next     = '0;
                pending_next = s_data.addr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            pending_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            pending_reg <= pending_next;
        end
    end

    assign status.busy     = busy_reg;
    assign status.resp_cnt = cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/itmag_queue.sv =====
// ----------------------------------------------------------------------------
// itmag_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module itmag_queue
    import itmag_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire q_push_t   push,
    input  wire logic      pop,
    output      cmd_t      head,
    output      q_status_t status
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign do_push = push.valid && (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/itmag_back.sv =====
// ----------------------------------------------------------------------------
// itmag_back
// Drains commands and expands each run into its metadata writes: MAC,
// counter block, then the tree levels, through a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module itmag_back
    import itmag_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cfg_t      cfg,
    input  wire cmd_t      head,
    input  wire q_status_t q_status,
    output      logic      pop,
    output      logic      m_valid,
    input  wire logic      m_ready,
    output      out_req_t  m_data
);

    bk_state_t         state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    aw_t               off_reg, off_next;
    aw_t               acc_reg, acc_next;
    aw_t               size_reg, size_next;
    logic              m_valid_reg, m_valid_next;
    out_req_t          m_data_reg, m_data_next;

    logic              out_free;
    logic              last_step;
    aw_t               head_off;
    aw_t               step_base;
    aw_t               step_addr;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (step_reg == STEP_W'(NUM_WRITES - 1));
    assign head_off  = (aw_t'(head.addr) >> 8) << 5;

    always_comb begin
        if (step_reg == STEP_W'(1)) begin
            step_base = aw_t'(cfg.counter_base);
        end else if (step_reg == STEP_W'(2)) begin
            step_base = aw_t'(cfg.tree_base);
        end else begin
            step_base = acc_reg;
        end
    end

    assign step_addr = step_base + off_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (out_free && !q_status.empty && head.op == CMD_RUN) begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                if (out_free && last_step) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        pop          = 1'b0;
        step_next    = step_reg;
        off_next     = off_reg;
        acc_next     = acc_reg;
        size_next    = size_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (out_free && !q_status.empty) begin
                    pop                     = 1'b1;
                    m_valid_next            = 1'b1;
                    m_data_next.out_addr    = head.addr;
                    m_data_next.size_bytes  = '0;
                    m_data_next.last        = 1'b0;
                    case (head.op)
                        CMD_RUN: begin
                            m_data_next.result_kind = RK_META;
                            m_data_next.out_addr    =
                                FIELD_W'(aw_t'(cfg.mac_base) + head_off);
                            m_data_next.size_bytes  = MAC_BYTES;
                            step_next = STEP_W'(1);
                            off_next  = (head_off >> 11) << 8;
                            acc_next  = aw_t'(cfg.tree_base) + FIRST_UPPER_SIZE;
                            size_next = FIRST_UPPER_SIZE >> 3;
                        end
                        CMD_REJECT:   m_data_next.result_kind = RK_BUSY;
                        CMD_ERROR:    m_data_next.result_kind = RK_RANGE;
                        CMD_COMPLETE: m_data_next.result_kind = RK_COMPLETE;
                        default:      m_data_next.result_kind = RK_COMPLETE;
                    endcase
                end
            end
            BK_RUN: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.result_kind = RK_META;
                    m_data_next.out_addr    = FIELD_W'(step_addr);
                    m_data_next.size_bytes  = BLOCK_BYTES;
                    m_data_next.last        = last_step;
                    step_next = step_reg + STEP_W'(1);
                    off_next  = (off_reg >> 11) << 8;
                    if (step_reg >= STEP_W'(3)) begin
                        acc_next  = acc_reg + size_reg;
                        size_next = size_reg >> 3;
                    end
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg    <= off_next;
        acc_reg    <= acc_next;
        size_reg   <= size_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/integrity_tree_metadata_address_gen.sv =====
// ----------------------------------------------------------------------------
// integrity_tree_metadata_address_gen
// Secure-memory write controller: turns a data write into its MAC, counter
// and integrity tree metadata writes, and reports run completion.
// ----------------------------------------------------------------------------
//   channel   ports                        payload
//   s_        s_valid / s_ready / s_data   in_req_t  (kind, addr)
//   m_        m_valid / m_ready / m_data   out_req_t (result_kind, out_addr,
//                                                     size_bytes, last)
//   cfg_      cfg_we / cfg_index / cfg_wdata   register write, no read-back
//
// A data write yields 3 + EXTRA_LEVELS (10) metadata writes, one per cycle
// while m_ready allows; counter and tree addresses share one back-end adder.
// The next command is popped as soon as the last write frees the result
// register, so results can run back to back. Rejects, range errors and
// completions yield one result each, registered after passing the queue.
// A 4-entry command queue decouples s_ from m_; s_ready drops only when full.
// Reset is synchronous on aresetn; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integrity_tree_metadata_address_gen_defines.svh"

module integrity_tree_metadata_address_gen
    import itmag_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [FIELD_W-1:0] cfg_wdata,
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire in_req_t            s_data,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      out_req_t           m_data
);

    cfg_t       cfg_reg;
    q_push_t    push;
    q_status_t  q_status;
    cmd_t       head;
    logic       pop;
    fe_status_t fe_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mac_base     <= '0;
            cfg_reg.counter_base <= '0;
            cfg_reg.tree_base    <= '0;
            cfg_reg.data_limit   <= DATA_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAC_BASE:     cfg_reg.mac_base     <= cfg_wdata;
                REG_COUNTER_BASE: cfg_reg.counter_base <= cfg_wdata;
                REG_TREE_BASE:    cfg_reg.tree_base    <= cfg_wdata;
                REG_DATA_LIMIT:   cfg_reg.data_limit   <= cfg_wdata;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    itmag_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .push     (push),
        .status   (fe_status)
    );

    itmag_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

    itmag_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    `ITMAG_ASSERT_NOW(a_idle_count_clear, !fe_status.busy, fe_status.resp_cnt == '0)
    `ITMAG_ASSERT_NOW(a_queue_bound, 1'b1, q_status.count <= QCNT_W'(QUEUE_DEPTH))
    `ITMAG_ASSERT_NOW(a_status_fields,
        m_valid && m_data.result_kind != RK_META,
        m_data.size_bytes == '0 && !m_data.last)
    `ITMAG_ASSERT_NEXT(a_full_stalls, q_status.full && !pop, !s_ready)

endmodule

`default_nettype wire

// ===== verif/integrity_tree_metadata_address_gen_tb.sv =====
// ----------------------------------------------------------------------------
// integrity_tree_metadata_address_gen_tb
// Drives data write requests and memory write responses into the metadata
// address generator under several region layouts. A local tree-walk predictor
// builds the expected metadata writes, rejects, range errors and completions,
// and every result is checked field by field in order. Both channels idle at
// random, and the result side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module integrity_tree_metadata_address_gen_tb;
    import itmag_pkg::*;

    localparam int   CYCLE_LIMIT   = 200000;
    localparam int   SETTLE_CYCLES = 64;
    localparam int   HOLD_CYCLES   = 300;
    localparam aw_t  ALL_ONES      = {ADDR_BITS{1'b1}};
    localparam aw_t  RESET_LIMIT   = 40'h04_0000_0000;
    localparam aw_t  L1_SPAN       = aw_t'(40'h00_1000_0000) >> 3;
    localparam logic [6:0] MAC_SIZE   = 7'd8;
    localparam logic [6:0] BLOCK_SIZE = 7'd64;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = REG_MAC_BASE;
    logic [FIELD_W-1:0] cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_req_t            s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_req_t           m_data;

    // predictor state
    cfg_t       layout;
    logic       run_open = 1'b0;
    logic [3:0] resp_seen = '0;
    aw_t        run_addr = '0;
    out_req_t   owed_results[$];

    in_req_t    send_q[$];
    int         queued_n = 0;
    int         taken_n = 0;
    int         mismatches = 0;
    int         cyc = 0;
    int         kind_seen[4] = '{0, 0, 0, 0};
    int         layouts_n = 1;
    logic       s_took = 1'b0;
    logic       hold_req = 1'b0;
    logic       hold_done = 1'b0;
    int         hold_left = 0;
    logic       quiet;

    integrity_tree_metadata_address_gen dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #6 aclk = ~aclk;

    assign quiet = (taken_n >= 150) && (taken_n < 230);

    initial begin
        layout.mac_base     = '0;
        layout.counter_base = '0;
        layout.tree_base    = '0;
        layout.data_limit   = RESET_LIMIT;
    end

    task automatic owe(logic [1:0] rk, aw_t a, logic [6:0] sz, logic lst);
        out_req_t r;
        r.result_kind = rk;
        r.out_addr    = a;
        r.size_bytes  = sz;
        r.last        = lst;
        owed_results.push_back(r);
    endtask

    task automatic derive_results(in_req_t req);
        aw_t off;
        aw_t lvl_base;
        aw_t lvl_span;
        if (req.kind == KIND_RESPONSE) begin
            if (!run_open) return;
            resp_seen = resp_seen + 4'd1;
            if (resp_seen >= RESPONSES_NEEDED) begin
                owe(RK_COMPLETE, run_addr, 7'd0, 1'b0);
                run_open  = 1'b0;
                resp_seen = '0;
            end
            return;
        end
        if (run_open) begin
            owe(RK_BUSY, req.addr, 7'd0, 1'b0);
            return;
        end
        if (req.addr >= layout.data_limit) begin
            owe(RK_RANGE, req.addr, 7'd0, 1'b0);
            return;
        end
        run_open  = 1'b1;
        resp_seen = '0;
        run_addr  = req.addr;
        off = (req.addr >> 8) << 5;
        owe(RK_META, layout.mac_base + off, MAC_SIZE, 1'b0);
        off = (off >> 11) << 8;
        owe(RK_META, layout.counter_base + off, BLOCK_SIZE, 1'b0);
        off = (off >> 11) << 8;
        owe(RK_META, layout.tree_base + off, BLOCK_SIZE, 1'(EXTRA_LEVELS == 0));
        lvl_base = layout.tree_base;
        lvl_span = L1_SPAN;
        for (int i = 0; i < EXTRA_LEVELS; i++) begin
            off      = (off >> 11) << 8;
            lvl_base = lvl_base + lvl_span;
            owe(RK_META, lvl_base + off, BLOCK_SIZE, 1'(i == EXTRA_LEVELS - 1));
            lvl_span = lvl_span >> 3;
        end
    endtask

    task automatic flag_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
    endtask

    // monitor: register writes, accepted requests and results, all at the rising edge
    always @(posedge aclk) begin
        out_req_t want;
        cyc++;
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAC_BASE:     layout.mac_base     = cfg_wdata;
                    REG_COUNTER_BASE: layout.counter_base = cfg_wdata;
                    REG_TREE_BASE:    layout.tree_base    = cfg_wdata;
                    REG_DATA_LIMIT:   layout.data_limit   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                derive_results(s_data);
                taken_n++;
            end
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    kind_seen[want.result_kind]++;
                    if (m_data.result_kind !== want.result_kind)
                        flag_field("result_kind", want.result_kind, m_data.result_kind);
                    if (m_data.out_addr !== want.out_addr)
                        flag_field("out_addr", want.out_addr, m_data.out_addr);
                    if (m_data.size_bytes !== want.size_bytes)
                        flag_field("size_bytes", want.size_bytes, m_data.size_bytes);
                    if (m_data.last !== want.last)
                        flag_field("last", want.last, m_data.last);
                end
            end
        end
        if (cyc > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, owed_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // request driver
    always @(negedge aclk) begin
        if (!s_valid || s_took) begin
            if (aresetn && send_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
                s_data  <= send_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= quiet || ($urandom_range(0, 99) >= 15);
        end
    end

    function automatic aw_t rand40();
        return aw_t'({$urandom, $urandom});
    endfunction

    function automatic aw_t addr_in_range();
        if (layout.data_limit == '0) return rand40();
        return aw_t'({$urandom, $urandom} % layout.data_limit);
    endfunction

    function automatic aw_t addr_out_of_range();
        logic [ADDR_BITS:0] span;
        span = {1'b1, {ADDR_BITS{1'b0}}} - layout.data_limit;
        return layout.data_limit + aw_t'({$urandom, $urandom} % span);
    endfunction

    task automatic queue_item(logic k, aw_t a);
        in_req_t r;
        r.kind = k;
        r.addr = a;
        send_q.push_back(r);
        queued_n++;
    endtask

    task automatic write_reg(logic [1:0] idx, aw_t v);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_layout(aw_t mac, aw_t ctr, aw_t tree, aw_t lim);
        write_reg(REG_MAC_BASE, mac);
        write_reg(REG_COUNTER_BASE, ctr);
        write_reg(REG_TREE_BASE, tree);
        write_reg(REG_DATA_LIMIT, lim);
        layouts_n++;
    endtask

    task automatic wait_drained();
        while (taken_n != queued_n || owed_results.size() != 0) @(negedge aclk);
    endtask

    // close any open run so the next register writes land on an idle block
    task automatic settle_phase();
        wait_drained();
        if (run_open) begin
            repeat (RESPONSES_NEEDED - resp_seen) queue_item(KIND_RESPONSE, rand40());
            wait_drained();
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic gen_traffic(int n);
        int k;
        int roll;
        k = 0;
        while (k < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                queue_item(KIND_WRITE, addr_in_range());
                k++;
                for (int j = 0; j < RESPONSES_NEEDED; j++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        queue_item(KIND_WRITE, rand40());
                        k++;
                    end
                    queue_item(KIND_RESPONSE, rand40());
                    k++;
                end
            end else if (roll < 80) begin
                queue_item(KIND_WRITE, addr_out_of_range());
                k++;
            end else if (roll < 90) begin
                queue_item(KIND_RESPONSE, rand40());
                k++;
            end else begin
                queue_item(KIND_WRITE, rand40());
                k++;
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // directed, reset layout
        queue_item(KIND_WRITE, '0);
        queue_item(KIND_WRITE, ALL_ONES);
        repeat (RESPONSES_NEEDED) queue_item(KIND_RESPONSE, ALL_ONES);
        queue_item(KIND_RESPONSE, '0);
        queue_item(KIND_WRITE, RESET_LIMIT - 40'd1);
        repeat (RESPONSES_NEEDED) queue_item(KIND_RESPONSE, '0);
        queue_item(KIND_WRITE, RESET_LIMIT);
        queue_item(KIND_WRITE, ALL_ONES);
        settle_phase();

        // everything at the top: region bases wrap, all but the top address protected
        set_layout(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        hold_req = 1'b1;
        gen_traffic(90);
        settle_phase();

        // nothing protected: every write is out of range
        set_layout('0, '0, '0, '0);
        gen_traffic(15);
        settle_phase();

        repeat (3) begin
            set_layout(rand40(), rand40(), rand40(),
                       $urandom_range(0, 1) ? RESET_LIMIT : rand40() | 40'h80_0000_0000);
            gen_traffic(80);
            settle_phase();
        end

        $display("Run covered %0d requests across %0d register layouts, incl. a %0d-cycle hold.",
                 taken_n, layouts_n, HOLD_CYCLES);
        $display("Results: %0d metadata writes, %0d busy, %0d range errors, %0d completions.",
                 kind_seen[RK_META], kind_seen[RK_BUSY], kind_seen[RK_RANGE],
                 kind_seen[RK_COMPLETE]);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
